// ===== sv/bac_pkg.sv =====
package bac_pkg;

  localparam int SECTOR_W = 48;
  localparam int COUNT_W  = 32;
  localparam int FREED_W  = 9;
  localparam int CFG_W    = 12;

  localparam logic [1:0] CMD_ACCESS = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] REG_DEVICE_MAJOR = 2'd0;
  localparam logic [1:0] REG_DEVICE_MINOR = 2'd1;
  localparam logic [1:0] REG_AGE_RELOAD   = 2'd2;

  localparam logic [7:0]         AGE_RELOAD_RESET = 8'd64;
  localparam logic [COUNT_W-1:0] COUNT_MAX        = 32'hffff_ffff;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [11:0]         event_major;
    logic [7:0]          event_minor;
    logic [SECTOR_W-1:0] sector;
    logic [7:0]          slot_index;
  } in_item_t;

  typedef struct packed {
    logic                accepted;
    logic                hit;
    logic                table_full;
    logic [COUNT_W-1:0]  access_count;
    logic [FREED_W-1:0]  freed_count;
    logic                slot_valid;
    logic [SECTOR_W-1:0] slot_address;
    logic [7:0]          slot_age;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC_SCAN,
    ST_ACC_FETCH,
    ST_ACC_UPDATE,
    ST_TICK_SCAN,
    ST_RD_FETCH,
    ST_RD_REPORT,
    ST_FINISH
  } state_t;

endpackage

// ===== sv/block_access_counter_with_aging.sv =====
// steps: an access scans the table (ending early on a hit), fetches and updates the picked slot;
// a tick scans every slot; a read fetches one slot; a device mismatch or unused command just finishes
// throughput: one transaction at a time, the next taken once the result goes valid; the
// one-slot-per-cycle scan over the table memories' single read port sets it
// reset: synchronous, clears the slot valid bits at once (no clearing pass), the
// configuration registers to their reset values and the result valid flag
module block_access_counter_with_aging
  import bac_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int ADDRESS_BITS  = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  in_item_t         cmd_data,
  output logic             res_valid,
  input  logic             res_ready,
  output out_item_t        res_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  // configuration registers
  logic [11:0] device_major;
  logic [7:0]  device_minor;
  logic [7:0]  age_reload;

  // table storage: valid bits in flops, the rest in memories
  logic [TABLE_ENTRIES-1:0] in_use;
  logic [ADDRESS_BITS-1:0]  mem_addr [TABLE_ENTRIES];
  logic [COUNT_W-1:0]       mem_hits [TABLE_ENTRIES];
  logic [7:0]               mem_life [TABLE_ENTRIES];
  logic [ADDRESS_BITS-1:0]  rd_addr_q;
  logic [COUNT_W-1:0]       rd_hits_q;
  logic [7:0]               rd_life_q;

  // sequencer registers
  state_t                  state, state_next;
  logic [IW-1:0]           ptr, ptr_next;
  logic                    issue_done, issue_done_next;
  logic                    cmp_vld, cmp_vld_next;
  logic [IW-1:0]           cmp_idx, cmp_idx_next;
  logic [ADDRESS_BITS-1:0] key, key_next;
  logic                    found, found_next;
  logic                    have_free, have_free_next;
  logic [IW-1:0]           pick, pick_next;
  logic [CW-1:0]           freed, freed_next;
  out_item_t               work, work_next;

  // memory control
  logic [IW-1:0]      rd_sel;
  logic [IW-1:0]      wr_sel;
  logic               addr_we, hits_we, life_we;
  logic [COUNT_W-1:0] hits_wdata;
  logic [7:0]         life_wdata;
  logic               use_set, use_clr;

  // shared compare / decrement unit and helpers
  logic [63:0]        sector_ext;
  logic [63:0]        key_ext;
  logic [63:0]        rd_addr_ext;
  logic [15:0]        idx_ext;
  logic               cmp_match, cmp_free, cmp_last;
  logic [7:0]         life_dec;
  logic [COUNT_W-1:0] count_new;

  assign cfg_ready   = 1'b1;
  assign cmd_ready   = (state == ST_IDLE);
  assign sector_ext  = {16'b0, cmd_data.sector};
  assign key_ext     = 64'(key);
  assign rd_addr_ext = 64'(rd_addr_q);
  assign idx_ext     = {8'b0, cmd_data.slot_index};

  // compare stage looks at the slot whose read was issued last cycle
  assign cmp_match = cmp_vld && in_use[cmp_idx] && (rd_addr_q == key);
  assign cmp_free  = cmp_vld && !in_use[cmp_idx];
  assign cmp_last  = cmp_vld && (cmp_idx == LAST);
  assign life_dec  = (rd_life_q == 8'd0) ? 8'd0 : rd_life_q - 8'd1;
  assign count_new = !found ? COUNT_W'(1) :
                     (rd_hits_q == COUNT_MAX) ? COUNT_MAX : rd_hits_q + COUNT_W'(1);

  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    issue_done_next = issue_done;
    cmp_vld_next    = 1'b0;
    cmp_idx_next    = cmp_idx;
    key_next        = key;
    found_next      = found;
    have_free_next  = have_free;
    pick_next       = pick;
    freed_next      = freed;
    work_next       = work;
    rd_sel          = ptr;
    wr_sel          = cmp_idx;
    addr_we         = 1'b0;
    hits_we         = 1'b0;
    life_we         = 1'b0;
    hits_wdata      = count_new;
    life_wdata      = life_dec;
    use_set         = 1'b0;
    use_clr         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          key_next        = sector_ext[ADDRESS_BITS-1:0];
          ptr_next        = '0;
          issue_done_next = 1'b0;
          found_next      = 1'b0;
          have_free_next  = 1'b0;
          freed_next      = '0;
          work_next       = '0;
          unique case (cmd_data.cmd)
            CMD_ACCESS: begin
              if (cmd_data.event_major == device_major &&
                  cmd_data.event_minor == device_minor) begin
                work_next.accepted = 1'b1;
                state_next         = ST_ACC_SCAN;
              end else begin
                state_next = ST_FINISH;
              end
            end
            CMD_TICK: begin
              state_next = ST_TICK_SCAN;
            end
            CMD_READ: begin
              pick_next  = idx_ext[IW-1:0];
              found_next = (idx_ext < 16'(TABLE_ENTRIES)) && in_use[idx_ext[IW-1:0]];
              state_next = ST_RD_FETCH;
            end
            default: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end

      ST_ACC_SCAN: begin
        // issue the next slot read while comparing the previous one
        if (!issue_done) begin
          cmp_vld_next    = 1'b1;
          cmp_idx_next    = ptr;
          ptr_next        = ptr + IW'(1);
          issue_done_next = (ptr == LAST);
        end
        if (cmp_match) begin
          found_next = 1'b1;
          pick_next  = cmp_idx;
          state_next = ST_ACC_FETCH;
        end else begin
          if (cmp_free && !have_free) begin
            have_free_next = 1'b1;
            pick_next      = cmp_idx;
          end
          if (cmp_last) begin
            if (have_free || cmp_free) begin
              state_next = ST_ACC_FETCH;
            end else begin
              work_next.table_full = 1'b1;
              state_next           = ST_FINISH;
            end
          end
        end
      end

      ST_ACC_FETCH: begin
        rd_sel     = pick;
        state_next = ST_ACC_UPDATE;
      end

      ST_ACC_UPDATE: begin
        // new entry or hit: count, age and (for new) address and valid bit
        wr_sel                 = pick;
        hits_we                = 1'b1;
        life_we                = 1'b1;
        life_wdata             = age_reload;
        addr_we                = !found;
        use_set                = !found;
        work_next.hit          = found;
        work_next.access_count = count_new;
        work_next.slot_valid   = 1'b1;
        work_next.slot_address = key_ext[SECTOR_W-1:0];
        work_next.slot_age     = age_reload;
        state_next             = ST_FINISH;
      end

      ST_TICK_SCAN: begin
        if (!issue_done) begin
          cmp_vld_next    = 1'b1;
          cmp_idx_next    = ptr;
          ptr_next        = ptr + IW'(1);
          issue_done_next = (ptr == LAST);
        end
        if (cmp_vld && in_use[cmp_idx]) begin
          life_we = 1'b1;
          if (life_dec == 8'd0) begin
            use_clr    = 1'b1;
            freed_next = freed + CW'(1);
          end
        end
        if (cmp_last) begin
          work_next.freed_count = FREED_W'(freed_next);
          state_next            = ST_FINISH;
        end
      end

      ST_RD_FETCH: begin
        rd_sel     = pick;
        state_next = ST_RD_REPORT;
      end

      ST_RD_REPORT: begin
        // found holds the in-range and in-use check made at acceptance
        if (found) begin
          work_next.access_count = rd_hits_q;
          work_next.slot_valid   = 1'b1;
          work_next.slot_address = rd_addr_ext[SECTOR_W-1:0];
          work_next.slot_age     = rd_life_q;
        end
        state_next = ST_FINISH;
      end

      ST_FINISH: begin
        // result moves to the output register once it is free
        if (!res_valid || res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_done <= 1'b0;
      cmp_vld    <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      issue_done <= issue_done_next;
      cmp_vld    <= cmp_vld_next;
      if (state == ST_FINISH && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
    ptr       <= ptr_next;
    cmp_idx   <= cmp_idx_next;
    key       <= key_next;
    found     <= found_next;
    have_free <= have_free_next;
    pick      <= pick_next;
    freed     <= freed_next;
    work      <= work_next;
    if (state == ST_FINISH && (!res_valid || res_ready)) begin
      res_data <= work;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (use_set) begin
      in_use[wr_sel] <= 1'b1;
    end else if (use_clr) begin
      in_use[wr_sel] <= 1'b0;
    end
  end

  // table memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (addr_we) begin
      mem_addr[wr_sel] <= key;
    end
    if (hits_we) begin
      mem_hits[wr_sel] <= hits_wdata;
    end
    if (life_we) begin
      mem_life[wr_sel] <= life_wdata;
    end
    rd_addr_q <= mem_addr[rd_sel];
    rd_hits_q <= mem_hits[rd_sel];
    rd_life_q <= mem_life[rd_sel];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      device_major <= 12'd0;
      device_minor <= 8'd0;
      age_reload   <= AGE_RELOAD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEVICE_MAJOR: device_major <= cfg_data;
        REG_DEVICE_MINOR: device_minor <= cfg_data[7:0];
        REG_AGE_RELOAD:   age_reload   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> state != ST_IDLE)
    else $error("sequencer stayed idle after a transaction");

  a_freed_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.freed_count <= FREED_W'(TABLE_ENTRIES))
    else $error("freed count exceeds table size");

  a_full_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.table_full |-> res_data.accepted && !res_data.hit &&
                                         !res_data.slot_valid)
    else $error("table full result carries slot data");

  a_hit_reports_slot: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.hit |-> res_data.accepted && res_data.slot_valid &&
                                  res_data.access_count != '0)
    else $error("hit without a reported slot");

  a_set_clr_apart: assert property (@(posedge clk) disable iff (rst)
    !(use_set && use_clr))
    else $error("valid bit set and cleared together");

endmodule

// ===== verif/block_access_counter_with_aging_test.sv =====
`timescale 1ns / 100ps

module block_access_counter_with_aging_test;
  import bac_pkg::*;

  localparam int TABLE_SLOTS    = 256;
  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 5;
  // quiet cycles before a register write, on top of an empty result queue
  localparam int CFG_SETTLE     = 8;
  // one full slot scan plus margin, waited out at the end
  localparam int DRAIN_CYCLES   = 300;
  // watchdog limit on cycles with no handshake, well above one full slot scan
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 50;
  localparam int HOT_SECTORS    = 16;
  // the one command code the package leaves unnamed
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ACT_ITEM,
    ACT_CFG,
    ACT_DRAIN,
    ACT_PACE
  } action_kind_t;

  typedef struct {
    action_kind_t     kind;
    in_item_t         item;
    logic [1:0]       reg_sel;
    logic [CFG_W-1:0] reg_value;
    int               gap_pct;
    int               stall_pct;
  } action_t;

  // dut ports, all inputs known from time zero
  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cmd_valid = 1'b0;
  logic             cmd_ready;
  in_item_t         cmd_data  = '0;
  logic             res_valid;
  logic             res_ready = 1'b0;
  out_item_t        res_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = REG_DEVICE_MAJOR;
  logic [CFG_W-1:0] cfg_data  = '0;

  block_access_counter_with_aging i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // own copy of the slot table and the device registers, at reset values
  bit                slot_used   [TABLE_SLOTS];
  bit [SECTOR_W-1:0] slot_sector [TABLE_SLOTS];
  bit [COUNT_W-1:0]  slot_hits   [TABLE_SLOTS];
  bit [7:0]          slot_life   [TABLE_SLOTS];
  logic [11:0]       dev_major   = '0;
  logic [7:0]        dev_minor   = '0;
  logic [7:0]        life_reload = AGE_RELOAD_RESET;

  action_t   pending_transactions [$];
  out_item_t expected_results     [$];

  // handshakes seen at the last rising edge, read by the driver at the falling one
  bit cmd_fire;
  bit cfg_fire;
  bit res_fire;
  int quiet_cycles;
  int error_count;
  int send_gap_pct;
  int recv_stall_pct;

  // device numbers the stimulus currently aims at
  logic [11:0] stim_major = '0;
  logic [7:0]  stim_minor = '0;

  // run statistics
  int cmd_counts [4];
  int hit_count;
  int full_count;
  int freed_total;
  int max_freed;
  int valid_reads;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  task automatic report_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      report_failure($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // walks the table the way the block does and returns the one result of a command
  function automatic out_item_t predict_table_result(input in_item_t it);
    out_item_t r;
    int        s;
    int        pick;
    int        n_freed;
    bit        found;
    bit        have_free;
    r         = '0;
    pick      = 0;
    n_freed   = 0;
    found     = 1'b0;
    have_free = 1'b0;
    case (it.cmd)
      CMD_ACCESS: begin
        // anything not from the monitored device leaves an all-zero result
        if (it.event_major == dev_major && it.event_minor == dev_minor) begin
          r.accepted = 1'b1;
          // a hit wins; otherwise remember the lowest free slot
          for (s = 0; s < TABLE_SLOTS && !found; s++) begin
            if (slot_used[s] && slot_sector[s] == it.sector) begin
              found = 1'b1;
              pick  = s;
            end else if (!slot_used[s] && !have_free) begin
              have_free = 1'b1;
              pick      = s;
            end
          end
          if (found) begin
            r.hit = 1'b1;
            if (slot_hits[pick] != COUNT_MAX) begin
              slot_hits[pick]++;
            end
          end else if (have_free) begin
            slot_used[pick]   = 1'b1;
            slot_sector[pick] = it.sector;
            slot_hits[pick]   = 1;
          end else begin
            // no room: flagged and dropped, no slot data reported
            r.table_full = 1'b1;
          end
          if (!r.table_full) begin
            slot_life[pick] = life_reload;
            r.slot_valid    = 1'b1;
            r.access_count  = slot_hits[pick];
            r.slot_address  = slot_sector[pick];
            r.slot_age      = slot_life[pick];
          end
        end
      end
      CMD_TICK: begin
        // ages saturate at zero, and a slot at zero after the tick is freed
        for (s = 0; s < TABLE_SLOTS; s++) begin
          if (slot_used[s]) begin
            if (slot_life[s] != 0) begin
              slot_life[s]--;
            end
            if (slot_life[s] == 0) begin
              slot_used[s] = 1'b0;
              n_freed++;
            end
          end
        end
        r.freed_count = n_freed[FREED_W-1:0];
      end
      CMD_READ: begin
        // a free slot reads as all zero
        if (slot_used[it.slot_index]) begin
          r.slot_valid   = 1'b1;
          r.access_count = slot_hits[it.slot_index];
          r.slot_address = slot_sector[it.slot_index];
          r.slot_age     = slot_life[it.slot_index];
        end
      end
      default: begin
        // unused command: no state change, all-zero result
      end
    endcase
    return r;
  endfunction

  function automatic logic [SECTOR_W-1:0] random_sector();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[SECTOR_W-1:0];
  endfunction

  task automatic push_item(input logic [1:0] cmd, input logic [11:0] major,
                           input logic [7:0] minor, input logic [SECTOR_W-1:0] sector,
                           input logic [7:0] index);
    action_t a;
    a.kind             = ACT_ITEM;
    a.item.cmd         = cmd;
    a.item.event_major = major;
    a.item.event_minor = minor;
    a.item.sector      = sector;
    a.item.slot_index  = index;
    pending_transactions.push_back(a);
  endtask

  // access from the device the block is currently set to monitor
  task automatic push_access(input logic [SECTOR_W-1:0] sector);
    push_item(CMD_ACCESS, stim_major, stim_minor, sector, 8'($urandom_range(255)));
  endtask

  // the fields a tick or a read ignores carry random junk
  task automatic push_tick();
    push_item(CMD_TICK, 12'($urandom_range(4095)), 8'($urandom_range(255)), random_sector(),
              8'($urandom_range(255)));
  endtask

  task automatic push_read(input logic [7:0] index);
    push_item(CMD_READ, 12'($urandom_range(4095)), 8'($urandom_range(255)), random_sector(),
              index);
  endtask

  task automatic push_cfg(input logic [1:0] sel, input logic [CFG_W-1:0] value);
    action_t a;
    a.kind      = ACT_CFG;
    a.reg_sel   = sel;
    a.reg_value = value;
    pending_transactions.push_back(a);
    if (sel == REG_DEVICE_MAJOR) begin
      stim_major = value[11:0];
    end else if (sel == REG_DEVICE_MINOR) begin
      stim_minor = value[7:0];
    end
  endtask

  // sender holds off until every expected result has come back
  task automatic push_drain();
    action_t a;
    a.kind = ACT_DRAIN;
    pending_transactions.push_back(a);
  endtask

  task automatic push_pace(input int gap, input int stall);
    action_t a;
    a.kind      = ACT_PACE;
    a.gap_pct   = gap;
    a.stall_pct = stall;
    pending_transactions.push_back(a);
  endtask

  // mostly well-formed accesses to a small set of hot sectors so that hits and
  // ageing interact; the rest is foreign devices, ticks, reads and unused commands
  task automatic push_random_mix(input int n);
    logic [SECTOR_W-1:0] hot [HOT_SECTORS];
    int                  k;
    int                  pick;
    for (k = 0; k < HOT_SECTORS; k++) begin
      hot[k] = random_sector();
    end
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        if ($urandom_range(9) < 8) begin
          push_access(hot[$urandom_range(HOT_SECTORS-1)]);
        end else begin
          push_access(random_sector());
        end
      end else if (pick < 78) begin
        push_item(CMD_ACCESS, 12'($urandom_range(4095)), 8'($urandom_range(255)),
                  random_sector(), 8'($urandom_range(255)));
      end else if (pick < 88) begin
        push_tick();
      end else if (pick < 98) begin
        if ($urandom_range(1) == 0) begin
          push_read(8'($urandom_range(HOT_SECTORS-1)));
        end else begin
          push_read(8'($urandom_range(255)));
        end
      end else begin
        push_item(CMD_UNUSED, 12'($urandom_range(4095)), 8'($urandom_range(255)),
                  random_sector(), 8'($urandom_range(255)));
      end
    end
  endtask

  // monitor: samples every handshake at the rising edge, predicts on each
  // accepted command and checks each accepted result against the oldest expectation
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      cmd_fire     = 1'b0;
      cfg_fire     = 1'b0;
      res_fire     = 1'b0;
      quiet_cycles = 0;
    end else begin
      cmd_fire = cmd_valid && cmd_ready;
      cfg_fire = cfg_valid && cfg_ready;
      res_fire = res_valid && res_ready;
      if (cfg_fire) begin
        case (cfg_index)
          REG_DEVICE_MAJOR: dev_major   = cfg_data[11:0];
          REG_DEVICE_MINOR: dev_minor   = cfg_data[7:0];
          REG_AGE_RELOAD:   life_reload = cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (res_fire) begin
        if (expected_results.size() == 0) begin
          report_failure($sformatf("result 0x%0h with no transaction outstanding", res_data));
        end else begin
          want = expected_results.pop_front();
          compare_field("accepted", 64'(res_data.accepted), 64'(want.accepted));
          compare_field("hit", 64'(res_data.hit), 64'(want.hit));
          compare_field("table_full", 64'(res_data.table_full), 64'(want.table_full));
          compare_field("access_count", 64'(res_data.access_count),
                        64'(want.access_count));
          compare_field("freed_count", 64'(res_data.freed_count), 64'(want.freed_count));
          compare_field("slot_valid", 64'(res_data.slot_valid), 64'(want.slot_valid));
          compare_field("slot_address", 64'(res_data.slot_address),
                        64'(want.slot_address));
          compare_field("slot_age", 64'(res_data.slot_age), 64'(want.slot_age));
        end
      end
      if (cmd_fire) begin
        want = predict_table_result(cmd_data);
        expected_results.push_back(want);
        cmd_counts[cmd_data.cmd]++;
        hit_count   += int'(want.hit);
        full_count  += int'(want.table_full);
        freed_total += int'(want.freed_count);
        if (int'(want.freed_count) > max_freed) begin
          max_freed = int'(want.freed_count);
        end
        if (cmd_data.cmd == CMD_READ && want.slot_valid) begin
          valid_reads++;
        end
      end
      quiet_cycles = (cmd_fire || cfg_fire || res_fire) ? 0 : quiet_cycles + 1;
    end
  end

  // driver: works through the pending transactions at the falling edge; every
  // driven signal gets exactly one nonblocking update per edge
  always @(negedge clk) begin : driver
    logic             nxt_cmd_valid;
    in_item_t         nxt_cmd_data;
    logic             nxt_cfg_valid;
    logic [1:0]       nxt_cfg_index;
    logic [CFG_W-1:0] nxt_cfg_data;
    action_t          act;
    nxt_cmd_valid = cmd_valid;
    nxt_cmd_data  = cmd_data;
    nxt_cfg_valid = cfg_valid;
    nxt_cfg_index = cfg_index;
    nxt_cfg_data  = cfg_data;
    if (rst) begin
      nxt_cmd_valid = 1'b0;
      nxt_cfg_valid = 1'b0;
    end else begin
      if (cmd_fire) begin
        nxt_cmd_valid = 1'b0;
      end
      if (cfg_fire) begin
        nxt_cfg_valid = 1'b0;
      end
      if (!nxt_cmd_valid && !nxt_cfg_valid && pending_transactions.size() != 0) begin
        act = pending_transactions[0];
        case (act.kind)
          ACT_ITEM: begin
            if ($urandom_range(99) >= send_gap_pct) begin
              nxt_cmd_valid = 1'b1;
              nxt_cmd_data  = act.item;
              void'(pending_transactions.pop_front());
            end
          end
          ACT_CFG: begin
            // registers only change with the block idle and every result home
            if (expected_results.size() == 0 && quiet_cycles >= CFG_SETTLE) begin
              nxt_cfg_valid = 1'b1;
              nxt_cfg_index = act.reg_sel;
              nxt_cfg_data  = act.reg_value;
              void'(pending_transactions.pop_front());
            end
          end
          ACT_DRAIN: begin
            if (expected_results.size() == 0) begin
              void'(pending_transactions.pop_front());
            end
          end
          ACT_PACE: begin
            send_gap_pct   = act.gap_pct;
            recv_stall_pct = act.stall_pct;
            void'(pending_transactions.pop_front());
          end
          default: begin
          end
        endcase
      end
    end
    cmd_valid <= nxt_cmd_valid;
    cmd_data  <= nxt_cmd_data;
    cfg_valid <= nxt_cfg_valid;
    cfg_index <= nxt_cfg_index;
    cfg_data  <= nxt_cfg_data;
    res_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // ends the run when no transaction of any kind moves for too long
  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : sequencer
    logic [SECTOR_W-1:0] fill_base;
    int                  k;

    // sender idles lightly while the receiver stalls hard
    push_pace(12, 58);

    // directed part, reset configuration: device 0/0, age reload 64
    push_read(8'd0);                                   // free slot reads as zero
    push_access('0);                                   // new entry in slot 0
    push_access('0);                                   // hit, count 2
    push_access('1);                                   // top address, slot 1
    push_item(CMD_ACCESS, 12'hfff, 8'hff, '0, 8'h00);  // foreign device
    push_item(CMD_ACCESS, 12'h000, 8'h01, '0, 8'h00);  // minor mismatch only
    push_item(CMD_ACCESS, 12'h001, 8'h00, '0, 8'h00);  // major mismatch only
    push_read(8'd0);
    push_read(8'd1);
    push_read(8'd255);
    push_tick();                                       // nothing freed, ages 63
    push_read(8'd1);
    push_item(CMD_UNUSED, 12'hfff, 8'hff, '1, 8'hff);  // unused command, all ones
    push_item(CMD_UNUSED, 12'($urandom_range(4095)), 8'($urandom_range(255)),
              random_sector(), 8'($urandom_range(255)));
    push_drain();

    // reload of zero: touched entries go at the next tick
    push_cfg(REG_AGE_RELOAD, 12'd0);
    push_access('0);
    push_access('1);
    push_access(48'd1);
    push_read(8'd2);
    push_tick();                                       // frees all three
    push_read(8'd0);

    // top device numbers, shortest real lifetime
    push_cfg(REG_DEVICE_MAJOR, 12'hfff);
    push_cfg(REG_DEVICE_MINOR, 12'h0ff);
    push_cfg(REG_AGE_RELOAD, 12'd1);
    push_access('1);
    push_item(CMD_ACCESS, 12'h000, 8'h00, '1, 8'h00);  // the old device no longer counts
    push_tick();                                       // table empty again

    // fill every slot from empty, overflow it, then age it all out with three ticks
    push_cfg(REG_DEVICE_MAJOR, CFG_W'($urandom_range(4095)));
    push_cfg(REG_DEVICE_MINOR, CFG_W'($urandom_range(255)));
    push_cfg(REG_AGE_RELOAD, 12'd3);
    fill_base = random_sector();
    for (k = 0; k < TABLE_SLOTS + 2; k++) begin
      push_access(fill_base + k);                      // last two are dropped
    end
    push_access(fill_base + 5);                        // hit still works when full
    push_item(CMD_ACCESS, ~stim_major, stim_minor, fill_base, 8'h00);
    push_read(8'd0);
    push_read(8'd128);
    push_read(8'd255);
    push_tick();
    push_tick();
    push_tick();                                       // all 256 freed at once
    push_drain();

    // random phases, each under its own device and lifetime settings
    push_cfg(REG_DEVICE_MAJOR, CFG_W'($urandom_range(4095)));
    push_cfg(REG_DEVICE_MINOR, CFG_W'($urandom_range(255)));
    push_cfg(REG_AGE_RELOAD, 12'd255);
    push_random_mix(100);
    push_cfg(REG_AGE_RELOAD, CFG_W'($urandom_range(1, 8)));
    push_random_mix(100);

    // now the sender idles hard and the receiver only lightly
    push_drain();
    push_pace(58, 12);
    push_cfg(REG_DEVICE_MAJOR, 12'h000);
    push_cfg(REG_DEVICE_MINOR, CFG_W'($urandom_range(255)));
    push_cfg(REG_AGE_RELOAD, CFG_W'($urandom_range(1, 255)));
    push_random_mix(200);

    // back to back, no idling on either side
    push_drain();
    push_pace(0, 0);
    push_cfg(REG_DEVICE_MAJOR, CFG_W'($urandom_range(4095)));
    push_cfg(REG_DEVICE_MINOR, 12'h000);
    push_cfg(REG_AGE_RELOAD, 12'd1);
    push_random_mix(100);
    push_cfg(REG_DEVICE_MAJOR, 12'hfff);
    push_cfg(REG_DEVICE_MINOR, 12'h0ff);
    push_cfg(REG_AGE_RELOAD, CFG_W'($urandom_range(2, 20)));
    push_random_mix(100);

    // single reset at the start of the run
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    while (pending_transactions.size() != 0 || cmd_valid || cfg_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    // anything arriving now is a stray result
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_failure($sformatf("%0d results never arrived", expected_results.size()));
    end

    $display("covered %0d accesses (%0d hits, %0d dropped on a full table), %0d ticks",
             cmd_counts[CMD_ACCESS], hit_count, full_count, cmd_counts[CMD_TICK]);
    $display("freeing %0d entries (up to %0d at once), %0d slot reads (%0d in use), %0d errors",
             freed_total, max_freed, cmd_counts[CMD_READ], valid_reads, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
